/* sv/assert_macros.svh */
// assertion macros used by the rtl file process_image_field_access.sv
// no dependencies; assertions compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define PIFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pifa assertion failed");

// condition must never be seen outside reset
`define PIFA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pifa forbidden condition seen");

`else

`define PIFA_ASSERT(lbl, clk, rst_n, prop)
`define PIFA_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* sv/pifa_pkg.sv */
// types, constants and helpers for the process image field access block
// no dependencies
package pifa_pkg;

  localparam int DATA_W          = 32;
  localparam int MAX_FIELD_BITS  = 32;
  localparam int IMAGE_BYTES_DEF = 256;
  localparam int LEN_W           = 6;
  // start bit = byte_offset*8 + bit_position + field_offset, at most 2110
  localparam int START_W         = 12;
  // index of the 32-bit word that holds the start bit
  localparam int WORD_W          = START_W - 5;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic              signed_field;
    logic [7:0]        byte_offset;
    logic [2:0]        bit_position;
    logic [5:0]        field_offset;
    logic [LEN_W-1:0]  field_length;
    logic [DATA_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              clamped;
    logic              range_error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_t;

  function automatic logic [START_W-1:0] start_bit(input in_item_t it);
    return START_W'({it.byte_offset, 3'b000}) + START_W'(it.bit_position)
         + START_W'(it.field_offset);
  endfunction

endpackage

/* sv/process_image_field_access.sv */
// top level of the process image field access block
// depends on pifa_pkg, pifa_image_mem and assert_macros.svh
//
// usage
//   in channel: an item (in_data) is taken at a rising edge where start is
//   high and busy is low. it names a field by byte offset, bit position and
//   field offset plus a length of 1 to 32 bits; func selects read or write.
//   out channel: one result per item, shown on out_data for exactly one
//   cycle with out_valid high. the receiver cannot hold it off.
//   the accepting edge moves the block into its modify cycle, and the edge
//   that ends it raises out_valid and registers the result on out_data.
//   no item is taken in the modify cycle: busy is high in the cycle after
//   an accept, while the two words under the field are read from the image
//   memory, modified and written back through its single write port per bank.
//   reset: synchronous, active low. afterwards a clearing pass zeroes the
//   image, one row of both banks per cycle over IMAGE_BYTES/8 rows rounded up,
//   with busy high; no item is taken until it is done.
//   a field out of the image or of bad length gives range_error and leaves
//   the image untouched.
module process_image_field_access #(
  parameter int IMAGE_BYTES = pifa_pkg::IMAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pifa_pkg::in_item_t  in_data,
  output logic                out_valid,
  output pifa_pkg::out_item_t out_data
);

  `include "assert_macros.svh"

  localparam int BANK_DEPTH = (IMAGE_BYTES + 7) / 8;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  // row math is done wide enough for both the item and the memory
  localparam int ROW_W      = ((BANK_AW > pifa_pkg::WORD_W) ? BANK_AW : pifa_pkg::WORD_W) + 1;
  localparam int BITS_W     = $clog2(IMAGE_BYTES * 8 + 1);
  localparam int CMP_W      = ((BITS_W > pifa_pkg::START_W) ? BITS_W : pifa_pkg::START_W) + 1;
  localparam logic [CMP_W-1:0]   IMAGE_BITS = CMP_W'(IMAGE_BYTES * 8);
  localparam logic [ROW_W-1:0]   ROW_LIMIT  = ROW_W'(BANK_DEPTH);
  localparam logic [BANK_AW-1:0] CLR_LAST   = BANK_AW'(BANK_DEPTH - 1);

  localparam int DW = pifa_pkg::DATA_W;

  // control state
  pifa_pkg::state_t state_r, state_nxt;
  logic [BANK_AW-1:0] clr_r, clr_nxt;
  logic               out_valid_r;

  // item held through the modify cycle
  pifa_pkg::in_item_t            item_r;
  logic [pifa_pkg::START_W-1:0]  start_r;
  logic [ROW_W-1:0]              row_even_r;
  logic [ROW_W-1:0]              row_odd_r;
  logic                          low_is_odd_r;
  pifa_pkg::out_item_t           out_data_r;

  // accept side
  logic                          acc;
  logic [pifa_pkg::START_W-1:0]  in_start;
  logic [pifa_pkg::WORD_W-1:0]   in_word;
  logic [ROW_W-1:0]              in_row_odd;
  logic [ROW_W-1:0]              in_row_even;

  // memory ports
  logic [DW-1:0]      rd_even, rd_odd;
  logic               we_even, we_odd;
  logic [BANK_AW-1:0] wr_row_even, wr_row_odd;
  logic [DW-1:0]      wr_even, wr_odd;

  // field datapath
  logic [pifa_pkg::LEN_W-1:0] len;
  logic [4:0]        sh;
  logic [63:0]       mask_w;
  logic [DW-1:0]     mask;
  logic [DW-1:0]     half;
  logic              err;
  logic [63:0]       window;
  logic [63:0]       shifted;
  logic [DW-1:0]     field;
  logic              field_msb;
  logic [DW-1:0]     read_val;
  logic signed [DW-1:0] upper;
  logic              uclip, sclip, clip;
  logic [DW-1:0]     bits;
  logic [63:0]       new_window;
  logic [DW-1:0]     even_new, odd_new;
  logic              do_write;
  pifa_pkg::out_item_t res;

  assign busy = (state_r != pifa_pkg::ST_IDLE);
  assign acc  = start && !busy;

  // the two consecutive words under the field sit in opposite banks
  assign in_start    = pifa_pkg::start_bit(in_data);
  assign in_word     = in_start[pifa_pkg::START_W-1:5];
  assign in_row_odd  = ROW_W'(in_word[pifa_pkg::WORD_W-1:1]);
  assign in_row_even = ROW_W'(in_word[pifa_pkg::WORD_W-1:1]) + ROW_W'(in_word[0]);

  pifa_image_mem #(
    .BANK_DEPTH (BANK_DEPTH),
    .BANK_AW    (BANK_AW)
  ) u_mem (
    .clk         (clk),
    .rd_en       (acc),
    .rd_row_even (in_row_even[BANK_AW-1:0]),
    .rd_row_odd  (in_row_odd[BANK_AW-1:0]),
    .rd_even     (rd_even),
    .rd_odd      (rd_odd),
    .we_even     (we_even),
    .we_odd      (we_odd),
    .wr_row_even (wr_row_even),
    .wr_row_odd  (wr_row_odd),
    .wr_even     (wr_even),
    .wr_odd      (wr_odd)
  );

  // ---------------------------------------------------------------------
  // field datapath, valid in the modify cycle
  // ---------------------------------------------------------------------
  always_comb begin
    len    = item_r.field_length;
    sh     = start_r[4:0];
    mask_w = (64'd1 << len) - 64'd1;
    mask   = mask_w[DW-1:0];
    half   = mask >> 1;

    err = (len == '0) || (len > pifa_pkg::LEN_W'(pifa_pkg::MAX_FIELD_BITS))
       || ((CMP_W'(start_r) + CMP_W'(len)) > IMAGE_BITS);

    // window low word is the word holding the start bit
    window    = low_is_odd_r ? {rd_even, rd_odd} : {rd_odd, rd_even};
    shifted   = window >> sh;
    field     = shifted[DW-1:0] & mask;
    // top bit of the field, bit len-1
    field_msb = |(field & (mask ^ half));
    read_val  = (item_r.signed_field && field_msb) ? (field | ~mask) : field;

    // saturation: signed value fits when all bits from len-1 up agree
    upper = $signed(item_r.write_value) >>> (len - pifa_pkg::LEN_W'(1));
    uclip = |(item_r.write_value & ~mask);
    sclip = !((upper == '0) || (upper == '1));
    if (item_r.signed_field) begin
      clip = sclip;
      if (sclip) begin
        bits = item_r.write_value[DW-1] ? (mask ^ half) : half;
      end else begin
        bits = item_r.write_value & mask;
      end
    end else begin
      clip = uclip;
      bits = uclip ? mask : item_r.write_value;
    end

    new_window = (window & ~({32'd0, mask} << sh)) | ({32'd0, bits} << sh);
    even_new   = low_is_odd_r ? new_window[63:32] : new_window[31:0];
    odd_new    = low_is_odd_r ? new_window[31:0]  : new_window[63:32];

    do_write = (item_r.func == pifa_pkg::FUNC_WRITE) && !err;

    res.range_error = err;
    res.clamped     = do_write && clip;
    res.read_value  = ((item_r.func == pifa_pkg::FUNC_READ) && !err) ? read_val : '0;
  end

  // ---------------------------------------------------------------------
  // sequencer: clearing pass, idle, modify cycle
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    we_even     = 1'b0;
    we_odd      = 1'b0;
    wr_row_even = row_even_r[BANK_AW-1:0];
    wr_row_odd  = row_odd_r[BANK_AW-1:0];
    wr_even     = even_new;
    wr_odd      = odd_new;
    case (state_r)
      pifa_pkg::ST_CLEAR: begin
        we_even     = 1'b1;
        we_odd      = 1'b1;
        wr_row_even = clr_r;
        wr_row_odd  = clr_r;
        wr_even     = '0;
        wr_odd      = '0;
        clr_nxt     = clr_r + BANK_AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = pifa_pkg::ST_IDLE;
        end
      end
      pifa_pkg::ST_IDLE: begin
        if (acc) begin
          state_nxt = pifa_pkg::ST_EXEC;
        end
      end
      pifa_pkg::ST_EXEC: begin
        // the upper word may lie past the image end when the field does not use it
        we_even   = do_write && (row_even_r < ROW_LIMIT);
        we_odd    = do_write && (row_odd_r < ROW_LIMIT);
        state_nxt = pifa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pifa_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pifa_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= (state_r == pifa_pkg::ST_EXEC);
    end
  end

  // item capture and result register
  always_ff @(posedge clk) begin
    if (acc) begin
      item_r       <= in_data;
      start_r      <= in_start;
      row_even_r   <= in_row_even;
      row_odd_r    <= in_row_odd;
      low_is_odd_r <= in_word[0];
    end
    if (state_r == pifa_pkg::ST_EXEC) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `PIFA_ASSERT(a_result_follows_modify, clk, rst_n,
    out_valid_r |-> $past(state_r == pifa_pkg::ST_EXEC))
  `PIFA_ASSERT(a_accept_enters_modify, clk, rst_n,
    acc |=> (state_r == pifa_pkg::ST_EXEC))
  `PIFA_ASSERT_NEVER(a_write_outside_work, clk, rst_n,
    (we_even || we_odd) && (state_r == pifa_pkg::ST_IDLE))
  `PIFA_ASSERT(a_error_result_clean, clk, rst_n,
    (out_valid_r && out_data_r.range_error)
      |-> ((out_data_r.read_value == '0) && !out_data_r.clamped))

endmodule

/* sv/pifa_image_mem.sv */
// process image storage: two banks of 32-bit words, even and odd word index
// depends on pifa_pkg
module pifa_image_mem #(
  parameter int BANK_DEPTH = (pifa_pkg::IMAGE_BYTES_DEF + 7) / 8,
  parameter int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [BANK_AW-1:0]            rd_row_even,
  input  logic [BANK_AW-1:0]            rd_row_odd,
  output logic [pifa_pkg::DATA_W-1:0]   rd_even,
  output logic [pifa_pkg::DATA_W-1:0]   rd_odd,
  input  logic                          we_even,
  input  logic                          we_odd,
  input  logic [BANK_AW-1:0]            wr_row_even,
  input  logic [BANK_AW-1:0]            wr_row_odd,
  input  logic [pifa_pkg::DATA_W-1:0]   wr_even,
  input  logic [pifa_pkg::DATA_W-1:0]   wr_odd
);

  logic [pifa_pkg::DATA_W-1:0] bank_even [BANK_DEPTH];
  logic [pifa_pkg::DATA_W-1:0] bank_odd  [BANK_DEPTH];
  logic [pifa_pkg::DATA_W-1:0] rd_even_r;
  logic [pifa_pkg::DATA_W-1:0] rd_odd_r;

  always_ff @(posedge clk) begin
    if (we_even) begin
      bank_even[wr_row_even[BANK_AW-1:0]] <= wr_even;
    end
    if (rd_en) begin
      rd_even_r <= bank_even[rd_row_even[BANK_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (we_odd) begin
      bank_odd[wr_row_odd[BANK_AW-1:0]] <= wr_odd;
    end
    if (rd_en) begin
      rd_odd_r <= bank_odd[rd_row_odd[BANK_AW-1:0]];
    end
  end

  assign rd_even = rd_even_r;
  assign rd_odd  = rd_odd_r;

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for the process image field access block
// depends on pifa_pkg and process_image_field_access; drives a directed table,
// then random reads and writes; checks each result against a typed or predicted value
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IMAGE_BYTES    = 256;
  localparam int          IMAGE_BITS     = IMAGE_BYTES * 8;
  localparam int          RANDOM_ITEMS   = 1030;
  localparam int          SEGMENT_ITEMS  = 64;
  localparam int          DRAIN_EVERY    = 250;
  localparam int          MAX_GAP        = 17;
  // the limit is several times the slowest legal run, with the longest
  // gaps between items and the clearing pass
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam logic        UNSIGNED_FIELD = 1'b0;
  localparam logic        SIGNED_FIELD   = 1'b1;
  localparam pifa_pkg::func_t OP_READ    = pifa_pkg::FUNC_READ;
  localparam pifa_pkg::func_t OP_WRITE   = pifa_pkg::FUNC_WRITE;

  // idle styles of the sender, picked per segment
  typedef enum int {
    PACE_BACK_TO_BACK = 0,
    PACE_RANDOM       = 1,
    PACE_SPARSE       = 2
  } pace_t;

  // one line of the directed table; known marks an expected result typed in
  typedef struct {
    pifa_pkg::in_item_t  acc;
    bit                  known;
    pifa_pkg::out_item_t res;
  } plan_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  pifa_pkg::in_item_t  in_data;
  logic                out_valid;
  pifa_pkg::out_item_t out_data;

  // predictor copy of the process image
  logic [7:0]  image_copy [IMAGE_BYTES];
  // expected results, oldest first
  pifa_pkg::out_item_t pending_results [$];
  plan_row_t   plan [$];
  int unsigned mismatches;
  int unsigned cycle_count;

  process_image_field_access #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // builds one access item
  function automatic pifa_pkg::in_item_t access(pifa_pkg::func_t f, logic sgn,
                                                int unsigned bofs, int unsigned bpos,
                                                int unsigned fofs, int unsigned len,
                                                logic [31:0] wval);
    pifa_pkg::in_item_t it;
    it.func         = f;
    it.signed_field = sgn;
    it.byte_offset  = 8'(bofs);
    it.bit_position = 3'(bpos);
    it.field_offset = 6'(fofs);
    it.field_length = pifa_pkg::LEN_W'(len);
    it.write_value  = wval;
    return it;
  endfunction

  function automatic pifa_pkg::out_item_t outcome(logic [31:0] rv, logic cl, logic re);
    pifa_pkg::out_item_t r;
    r.read_value  = rv;
    r.clamped     = cl;
    r.range_error = re;
    return r;
  endfunction

  function automatic plan_row_t row(pifa_pkg::in_item_t a, bit k, pifa_pkg::out_item_t r);
    plan_row_t p;
    p.acc   = a;
    p.known = k;
    p.res   = r;
    return p;
  endfunction

  // computes the result of one access and applies a write to the image copy
  function automatic pifa_pkg::out_item_t field_access_predict(pifa_pkg::in_item_t it);
    pifa_pkg::out_item_t r;
    int unsigned first;
    int unsigned len;
    int unsigned pos;
    logic [63:0] mask;
    logic [63:0] bits;
    longint      sval;
    longint      hi;
    longint      lo;
    bit          clip;
    r     = '0;
    len   = int'(it.field_length);
    first = int'({it.byte_offset, 3'b000}) + int'(it.bit_position)
          + int'(it.field_offset);
    if (len == 0 || len > pifa_pkg::MAX_FIELD_BITS || first + len > IMAGE_BITS) begin
      r.range_error = 1'b1;
      return r;
    end
    mask = (64'd1 << len) - 64'd1;
    bits = '0;
    clip = 1'b0;
    if (it.func == OP_READ) begin
      for (int i = 0; i < len; i++) begin
        pos     = first + i;
        bits[i] = image_copy[pos >> 3][pos & 7];
      end
      // sign extension from the top bit of the field, any alignment
      if (it.signed_field && bits[len-1])
        bits = bits | ~mask;
      r.read_value = bits[31:0];
    end else begin
      if (it.signed_field) begin
        sval = longint'($signed(it.write_value));
        hi   = (longint'(1) << (len - 1)) - 1;
        lo   = -hi - 1;
        if (sval > hi) begin
          sval = hi;
          clip = 1'b1;
        end
        if (sval < lo) begin
          sval = lo;
          clip = 1'b1;
        end
        bits = 64'(sval) & mask;
      end else begin
        bits = {32'd0, it.write_value};
        if (bits > mask) begin
          bits = mask;
          clip = 1'b1;
        end
      end
      for (int i = 0; i < len; i++) begin
        pos = first + i;
        image_copy[pos >> 3][pos & 7] = bits[i];
      end
      r.clamped = clip;
    end
    return r;
  endfunction

  function automatic int unsigned draw_gap(pace_t pace);
    case (pace)
      PACE_BACK_TO_BACK: return 0;
      PACE_SPARSE:       return ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      default:           return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  // presents one item after gap idle cycles and holds it until taken
  task automatic issue(pifa_pkg::in_item_t it, bit known, pifa_pkg::out_item_t typed,
                       int unsigned gap);
    pifa_pkg::out_item_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    // taken at the first rising edge with busy low
    do @(posedge clk); while (busy);
    predicted = field_access_predict(it);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // drop start so the last item is not taken again, then wait for all results
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker: one strobe, one expectation
  always @(posedge clk) begin
    pifa_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value=%h clamped=%b range_error=%b",
               out_data.read_value, out_data.clamped, out_data.range_error);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value expected %h actual %h", want.read_value,
                 out_data.read_value);
          mismatches++;
        end
        if (out_data.clamped !== want.clamped) begin
          $error("clamped expected %b actual %b", want.clamped, out_data.clamped);
          mismatches++;
        end
        if (out_data.range_error !== want.range_error) begin
          $error("range_error expected %b actual %b", want.range_error,
                 out_data.range_error);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pifa_pkg::in_item_t it;
    pace_t       pace;
    int unsigned len;
    int unsigned pick;
    int unsigned bofs;
    logic [31:0] span;
    logic [31:0] half;
    logic [31:0] wval;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    mismatches  = 0;
    cycle_count = 0;
    foreach (image_copy[b]) image_copy[b] = 8'h00;

    // directed table, typed results only where they are obvious
    // image is all zero after reset
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 0, 0, 0, 32, 0), 1,
                       outcome(32'h0, 1'b0, 1'b0)));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 128, 4, 9, 17, 0), 1,
                       outcome(32'h0, 1'b0, 1'b0)));
    // highest start bit, far past the image end
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 255, 7, 63, 1, 0), 1,
                       outcome(32'h0, 1'b0, 1'b1)));
    // bad lengths: zero, one above the maximum, the largest code
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 0, 0, 0, 0, 0), 1,
                       outcome(32'h0, 1'b0, 1'b1)));
    plan.push_back(row(access(OP_WRITE, UNSIGNED_FIELD, 8, 0, 0, 33, 32'h1), 1,
                       outcome(32'h0, 1'b0, 1'b1)));
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 8, 0, 0, 63, 32'hFFFFFFFF), 1,
                       outcome(32'h0, 1'b0, 1'b1)));
    // full-width writes never clamp
    plan.push_back(row(access(OP_WRITE, UNSIGNED_FIELD, 0, 0, 0, 32, 32'hFFFFFFFF), 1,
                       outcome(32'h0, 1'b0, 1'b0)));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 0, 0, 0, 32, 0), 1,
                       outcome(32'hFFFFFFFF, 1'b0, 1'b0)));
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 20, 3, 5, 32, 32'h80000000), 1,
                       outcome(32'h0, 1'b0, 1'b0)));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 20, 3, 5, 32, 0), 0, '0));
    // unsigned clamp to the top of an 8-bit field, unaligned
    plan.push_back(row(access(OP_WRITE, UNSIGNED_FIELD, 4, 3, 0, 8, 32'h1FF), 1,
                       outcome(32'h0, 1'b1, 1'b0)));
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 4, 3, 0, 8, 0), 0, '0));
    // signed clamps at both ends
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 40, 0, 0, 8, 32'h80), 1,
                       outcome(32'h0, 1'b1, 1'b0)));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 40, 0, 0, 8, 0), 0, '0));
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 44, 6, 1, 5, 32'hFFFFFF00), 1,
                       outcome(32'h0, 1'b1, 1'b0)));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 44, 6, 1, 5, 0), 0, '0));
    // one-bit signed field holds only 0 and -1
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 60, 2, 0, 1, 32'h1), 1,
                       outcome(32'h0, 1'b1, 1'b0)));
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 61, 5, 0, 1, 32'hFFFFFFFF), 0, '0));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 61, 5, 0, 1, 0), 0, '0));
    // sign extension of a field that starts mid-byte and spans bytes
    plan.push_back(row(access(OP_WRITE, SIGNED_FIELD, 10, 5, 17, 12, 32'hFFFFFFFB), 0, '0));
    plan.push_back(row(access(OP_READ, SIGNED_FIELD, 10, 5, 17, 12, 0), 0, '0));
    // field across five bytes with the largest field offset
    plan.push_back(row(access(OP_WRITE, UNSIGNED_FIELD, 100, 7, 63, 32, 32'hA5C3_1E69), 0, '0));
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 100, 7, 63, 32, 0), 0, '0));
    // last fitting field at the image end, then one bit too far
    plan.push_back(row(access(OP_WRITE, UNSIGNED_FIELD, 252, 0, 0, 32, 32'h8000_0001), 0, '0));
    plan.push_back(row(access(OP_READ, UNSIGNED_FIELD, 252, 1, 0, 32, 0), 1,
                       outcome(32'h0, 1'b0, 1'b1)));

    // hold reset, then release it at a falling edge before any item
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[k])
      issue(plan[k].acc, plan[k].known, plan[k].res, draw_gap(PACE_RANDOM));

    // random part: mostly legal accesses packed into a few regions so that
    // reads return data from earlier writes
    pace = PACE_RANDOM;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_ITEMS == 0)
        pace = pace_t'($urandom_range(0, 2));
      // hold off until the block has delivered everything
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1)
        drain_results();

      pick = $urandom_range(0, 99);
      if (pick < 4)
        len = 0;
      else if (pick < 8)
        len = $urandom_range(33, 63);
      else if (pick < 20)
        len = 32;
      else if (pick < 28)
        len = 1;
      else
        len = $urandom_range(1, 32);

      pick = $urandom_range(0, 99);
      if (pick < 50)
        bofs = $urandom_range(0, 15);
      else if (pick < 65)
        bofs = $urandom_range(240, 255);
      else
        bofs = $urandom_range(0, 255);

      // range limits of the field, at most 32 bits for the value math
      span = (len >= 32 || len == 0) ? 32'hFFFFFFFF : (32'h1 << len) - 32'h1;
      half = span >> 1;
      case ($urandom_range(0, 5))
        0:       wval = $urandom_range(0, span);
        1:       wval = ($urandom_range(0, 1) != 0) ? span : span + 32'h1;
        2: begin
          case ($urandom_range(0, 3))
            0:       wval = half;
            1:       wval = half + 32'h1;
            2:       wval = ~half;
            default: wval = ~half - 32'h1;
          endcase
        end
        3:       wval = -32'($urandom_range(1, 100));
        default: wval = $urandom();
      endcase

      it = access(pifa_pkg::func_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  bofs, $urandom_range(0, 7),
                  ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 63), len, wval);
      issue(it, 0, '0, draw_gap(pace));
    end

    @(negedge clk);
    start <= 1'b0;

    drain_results();
    // wait on so that a stray strobe is caught
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
